@@ rtl/utf8_edit_distance_core_defines.svh @@
// ----------------------------------------------------------------------------
// utf8_edit_distance_core_defines.svh
// Assertion macros shared by the edit distance RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_EDIT_DISTANCE_CORE_DEFINES_SVH
`define UTF8_EDIT_DISTANCE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define U8ED_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define U8ED_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8ED_ASSERT(label, clk, rst_n, prop, msg)
`define U8ED_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ rtl/u8ed_pkg.sv @@
// ----------------------------------------------------------------------------
// u8ed_pkg
// Types, codes and helpers of the UTF-8 edit distance core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8ed_pkg;

    localparam int MAX_CHARS_DEF = 64;
    localparam int BYTES_MAX     = 7;
    localparam int CHAR_DATA_W   = 8 * BYTES_MAX;
    localparam int CHAR_W        = CHAR_DATA_W + 3;   // bytes plus byte count
    localparam int DIST_W        = 7;
    localparam int LEAD_RUN_MAX  = 6;

    localparam logic [1:0] OP_FIRST  = 2'd0;
    localparam logic [1:0] OP_SECOND = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } t_cmd;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_result;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_INIT,
        DP_ROW,
        DP_RUN,
        DP_DONE
    } t_dp_state;

    // control from the DP engine to the assembler
    typedef struct packed {
        logic clear;
    } t_asm_ctl;

    // bytes in a character, from its lead byte
    function automatic logic [2:0] lead_count(input logic [7:0] b);
        logic [2:0] n;
        logic       run;
        n   = 3'd1;
        run = b[7];
        for (int k = 0; k < LEAD_RUN_MAX; k++) begin
            run = run & b[6-k];
            if (run) begin
                n = n + 3'd1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/utf8_edit_distance_core.sv @@
// ----------------------------------------------------------------------------
// utf8_edit_distance_core
// Character-level Levenshtein distance between two UTF-8 byte strings.
//
// Feed bytes with start while busy is low: op FIRST or SECOND tags the byte
// with its string. Bytes are grouped into characters by the lead byte (run
// of leading ones, at most 7 bytes); a character cut short by a string
// switch or by finish is kept short. Byte words leave busy low, so bytes
// can stream every cycle. A FINISH word raises busy while the DP matrix is
// swept through a row RAM, one cell per cycle within a row. The result sits
// on o_result with o_valid high for exactly one cycle, the last busy one;
// there is no backpressure, so it must be taken then. More than MAX_CHARS
// characters in either string gives overflow = 1 and distance = MAX_CHARS.
// After the result both strings are cleared. Op code 3 is ignored.
// Character RAMs need no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_edit_distance_core #(
    parameter int MAX_CHARS = u8ed_pkg::MAX_CHARS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire u8ed_pkg::t_cmd    i_cmd,
    output logic                   o_valid,
    output u8ed_pkg::t_result      o_result
);

    // length counters hold 0..MAX_CHARS, addresses 0..MAX_CHARS-1
    localparam int LEN_W  = $clog2(MAX_CHARS + 1);
    localparam int ADDR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

    logic                         accept, take, finish;

    logic                         we1, we2;
    logic [ADDR_W-1:0]            waddr1, waddr2;
    logic [u8ed_pkg::CHAR_W-1:0]  wdata1, wdata2;
    logic [LEN_W-1:0]             len1, len2;
    logic                         ovf;

    logic                         first_re, second_re;
    logic [ADDR_W-1:0]            first_raddr, second_raddr;
    logic [u8ed_pkg::CHAR_W-1:0]  first_rd, second_rd;

    logic [LEN_W-1:0]             dp_dist;
    u8ed_pkg::t_asm_ctl           asm_ctl;

    // a word is taken when start meets a free core
    assign accept = start && !busy;
    assign take   = accept && ((i_cmd.op == u8ed_pkg::OP_FIRST) ||
                               (i_cmd.op == u8ed_pkg::OP_SECOND));
    assign finish = accept && (i_cmd.op == u8ed_pkg::OP_FINISH);

    // character assembly and appends to both string stores
    u8ed_asm #(
        .MAX_CHARS (MAX_CHARS),
        .LEN_W     (LEN_W),
        .ADDR_W    (ADDR_W)
    ) u_asm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_finish (finish),
        .i_cmd    (i_cmd),
        .i_ctl    (asm_ctl),
        .o_we1    (we1),
        .o_waddr1 (waddr1),
        .o_wdata1 (wdata1),
        .o_we2    (we2),
        .o_waddr2 (waddr2),
        .o_wdata2 (wdata2),
        .o_len1   (len1),
        .o_len2   (len2),
        .o_ovf    (ovf)
    );

    // first string: one read per DP row
    u8ed_ram #(
        .WIDTH (u8ed_pkg::CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr1),
        .i_wdata (wdata1),
        .i_re    (first_re),
        .i_raddr (first_raddr),
        .o_rdata (first_rd)
    );

    // second string: one read per DP cell
    u8ed_ram #(
        .WIDTH (u8ed_pkg::CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (waddr2),
        .i_wdata (wdata2),
        .i_re    (second_re),
        .i_raddr (second_raddr),
        .o_rdata (second_rd)
    );

    // matrix sweep; holds busy until the result cycle
    u8ed_dp #(
        .MAX_CHARS (MAX_CHARS),
        .LEN_W     (LEN_W),
        .ADDR_W    (ADDR_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_finish       (finish),
        .i_len1         (len1),
        .i_len2         (len2),
        .i_ovf          (ovf),
        .i_first_rd     (first_rd),
        .i_second_rd    (second_rd),
        .o_first_re     (first_re),
        .o_first_raddr  (first_raddr),
        .o_second_re    (second_re),
        .o_second_raddr (second_raddr),
        .o_busy         (busy),
        .o_done         (o_valid),
        .o_dist         (dp_dist),
        .o_ctl          (asm_ctl)
    );

    // overflow flag is still set in the result cycle, cleared at its end
    always_comb begin
        o_result.distance = u8ed_pkg::DIST_W'(dp_dist);
        o_result.overflow = ovf;
    end

endmodule

`default_nettype wire

@@ rtl/u8ed_ram.sv @@
// ----------------------------------------------------------------------------
// u8ed_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8ed_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/u8ed_asm.sv @@
// ----------------------------------------------------------------------------
// u8ed_asm
// Groups bytes into characters and appends them to the string stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_edit_distance_core_defines.svh"

module u8ed_asm #(
    parameter int MAX_CHARS = u8ed_pkg::MAX_CHARS_DEF,
    parameter int LEN_W     = $clog2(MAX_CHARS + 1),
    parameter int ADDR_W    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_take,
    input  wire logic                       i_finish,
    input  wire u8ed_pkg::t_cmd             i_cmd,
    input  wire u8ed_pkg::t_asm_ctl         i_ctl,
    output logic                            o_we1,
    output logic [ADDR_W-1:0]               o_waddr1,
    output logic [u8ed_pkg::CHAR_W-1:0]     o_wdata1,
    output logic                            o_we2,
    output logic [ADDR_W-1:0]               o_waddr2,
    output logic [u8ed_pkg::CHAR_W-1:0]     o_wdata2,
    output logic [LEN_W-1:0]                o_len1,
    output logic [LEN_W-1:0]                o_len2,
    output logic                            o_ovf
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CHARS);

    logic [u8ed_pkg::CHAR_DATA_W-1:0] r_asm, n_asm;
    logic [2:0]                       r_cnt, n_cnt;
    logic [2:0]                       r_exp, n_exp;
    logic                             r_tgt, n_tgt;
    logic [LEN_W-1:0]                 r_len1, n_len1;
    logic [LEN_W-1:0]                 r_len2, n_len2;
    logic                             r_ovf, n_ovf;

    logic                             pend, start_new, commit_a, commit_b;
    logic                             hit1, hit2;
    logic [u8ed_pkg::CHAR_DATA_W-1:0] asm_b;
    logic [2:0]                       cnt_b, exp_b;
    logic                             tgt_b;
    logic [u8ed_pkg::CHAR_W-1:0]      word_a, word_b;

    // byte path: close a pending char on string switch or finish, then add the byte
    always_comb begin
        pend      = (r_cnt != 3'd0);
        start_new = !pend || (r_tgt != i_cmd.op[0]);
        commit_a  = pend && ((i_take && (r_tgt != i_cmd.op[0])) || i_finish);
        word_a    = {r_cnt, r_asm};

        asm_b = r_asm;
        if (start_new) begin
            asm_b = {{(u8ed_pkg::CHAR_DATA_W - 8){1'b0}}, i_cmd.data_byte};
            cnt_b = 3'd1;
            exp_b = u8ed_pkg::lead_count(i_cmd.data_byte);
            tgt_b = i_cmd.op[0];
        end else begin
            for (int k = 0; k < u8ed_pkg::BYTES_MAX; k++) begin
                if (r_cnt == 3'(k)) begin
                    asm_b[8*k +: 8] = i_cmd.data_byte;
                end
            end
            cnt_b = r_cnt + 3'd1;
            exp_b = r_exp;
            tgt_b = r_tgt;
        end
        commit_b = i_take && (cnt_b >= exp_b);
        word_b   = {cnt_b, asm_b};

        hit1 = (commit_a && !r_tgt) || (commit_b && !tgt_b);
        hit2 = (commit_a && r_tgt) || (commit_b && tgt_b);
    end

    always_comb begin
        o_we1    = hit1 && (r_len1 < LEN_MAX);
        o_we2    = hit2 && (r_len2 < LEN_MAX);
        o_waddr1 = r_len1[ADDR_W-1:0];
        o_waddr2 = r_len2[ADDR_W-1:0];
        o_wdata1 = (commit_a && !r_tgt) ? word_a : word_b;
        o_wdata2 = (commit_a && r_tgt) ? word_a : word_b;
        o_len1   = r_len1;
        o_len2   = r_len2;
        o_ovf    = r_ovf;
    end

    always_comb begin
        n_asm  = r_asm;
        n_cnt  = r_cnt;
        n_exp  = r_exp;
        n_tgt  = r_tgt;
        n_len1 = o_we1 ? r_len1 + LEN_W'(1) : r_len1;
        n_len2 = o_we2 ? r_len2 + LEN_W'(1) : r_len2;
        n_ovf  = r_ovf || (hit1 && !o_we1) || (hit2 && !o_we2);
        if (i_ctl.clear) begin
            n_asm  = '0;
            n_cnt  = 3'd0;
            n_exp  = 3'd0;
            n_tgt  = 1'b0;
            n_len1 = '0;
            n_len2 = '0;
            n_ovf  = 1'b0;
        end else if (i_take) begin
            n_tgt = tgt_b;
            if (commit_b) begin
                n_asm = '0;
                n_cnt = 3'd0;
                n_exp = 3'd0;
            end else begin
                n_asm = asm_b;
                n_cnt = cnt_b;
                n_exp = exp_b;
            end
        end else if (commit_a) begin
            n_asm = '0;
            n_cnt = 3'd0;
            n_exp = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asm  <= '0;
            r_cnt  <= 3'd0;
            r_exp  <= 3'd0;
            r_tgt  <= 1'b0;
            r_len1 <= '0;
            r_len2 <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_asm  <= n_asm;
            r_cnt  <= n_cnt;
            r_exp  <= n_exp;
            r_tgt  <= n_tgt;
            r_len1 <= n_len1;
            r_len2 <= n_len2;
            r_ovf  <= n_ovf;
        end
    end

    `U8ED_ASSERT(a_len_bound, i_clk, i_rst_n, (r_len1 <= LEN_MAX) && (r_len2 <= LEN_MAX), "string length past limit")
    `U8ED_ASSERT(a_pend_short, i_clk, i_rst_n, (r_cnt != 3'd0) |-> (r_cnt < r_exp), "pending char should have been stored")
    `U8ED_ASSERT(a_clear, i_clk, i_rst_n, i_ctl.clear |=> ((r_len1 == '0) && (r_len2 == '0) && !r_ovf && (r_cnt == 3'd0)), "clear did not empty the strings")

endmodule

`default_nettype wire

@@ rtl/u8ed_dp.sv @@
// ----------------------------------------------------------------------------
// u8ed_dp
// DP sequencer: sweeps the distance matrix row by row through dp_row RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_edit_distance_core_defines.svh"

module u8ed_dp #(
    parameter int MAX_CHARS = u8ed_pkg::MAX_CHARS_DEF,
    parameter int LEN_W     = $clog2(MAX_CHARS + 1),
    parameter int ADDR_W    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_finish,
    input  wire logic [LEN_W-1:0]           i_len1,
    input  wire logic [LEN_W-1:0]           i_len2,
    input  wire logic                       i_ovf,
    input  wire logic [u8ed_pkg::CHAR_W-1:0] i_first_rd,
    input  wire logic [u8ed_pkg::CHAR_W-1:0] i_second_rd,
    output logic                            o_first_re,
    output logic [ADDR_W-1:0]               o_first_raddr,
    output logic                            o_second_re,
    output logic [ADDR_W-1:0]               o_second_raddr,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [LEN_W-1:0]                o_dist,
    output u8ed_pkg::t_asm_ctl              o_ctl
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CHARS);
    localparam logic [LEN_W-1:0] ONE     = LEN_W'(1);

    u8ed_pkg::t_dp_state r_state, n_state;
    logic [LEN_W-1:0]    r_i, n_i;
    logic [LEN_W-1:0]    r_j, n_j;
    logic [LEN_W-1:0]    r_left, n_left;
    logic [LEN_W-1:0]    r_diag, n_diag;
    logic [LEN_W-1:0]    r_res, n_res;

    logic                dp_we, dp_re;
    logic [ADDR_W-1:0]   dp_waddr, dp_raddr;
    logic [LEN_W-1:0]    dp_wdata, dp_rdata;
    logic [LEN_W-1:0]    best, cost;
    logic                init_last, row_last;

    u8ed_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_CHARS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (dp_we),
        .i_waddr (dp_waddr),
        .i_wdata (dp_wdata),
        .i_re    (dp_re),
        .i_raddr (dp_raddr),
        .o_rdata (dp_rdata)
    );

    // one cell: dp_rdata is the entry above, r_left and r_diag the neighbors
    always_comb begin
        best = r_left;
        if (dp_rdata < best) begin
            best = dp_rdata;
        end
        if (r_diag < best) begin
            best = r_diag;
        end
        cost = (i_first_rd == i_second_rd) ? r_diag : best + ONE;
    end

    assign init_last = (r_j >= i_len2);
    assign row_last  = (r_j >= i_len2);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            u8ed_pkg::DP_IDLE: begin
                if (i_finish) begin
                    n_state = u8ed_pkg::DP_INIT;
                end
            end
            u8ed_pkg::DP_INIT: begin
                if (i_ovf || i_len1 == '0 || i_len2 == '0) begin
                    n_state = (i_ovf || init_last) ? u8ed_pkg::DP_DONE : r_state;
                end else if (init_last) begin
                    n_state = u8ed_pkg::DP_ROW;
                end
            end
            u8ed_pkg::DP_ROW: begin
                n_state = u8ed_pkg::DP_RUN;
            end
            u8ed_pkg::DP_RUN: begin
                if (row_last) begin
                    n_state = (r_i < i_len1) ? u8ed_pkg::DP_ROW : u8ed_pkg::DP_DONE;
                end
            end
            u8ed_pkg::DP_DONE: begin
                n_state = u8ed_pkg::DP_IDLE;
            end
            default: begin
                n_state = u8ed_pkg::DP_IDLE;
            end
        endcase
    end

    // memory controls and status
    always_comb begin
        dp_we          = 1'b0;
        dp_waddr       = ADDR_W'(r_j - ONE);
        dp_wdata       = r_j;
        dp_re          = 1'b0;
        dp_raddr       = r_j[ADDR_W-1:0];
        o_first_re     = 1'b0;
        o_first_raddr  = ADDR_W'(r_i - ONE);
        o_second_re    = 1'b0;
        o_second_raddr = r_j[ADDR_W-1:0];
        o_busy         = 1'b1;
        o_done         = 1'b0;
        o_ctl.clear    = 1'b0;
        case (r_state)
            u8ed_pkg::DP_IDLE: begin
                o_busy = 1'b0;
            end
            u8ed_pkg::DP_INIT: begin
                dp_we = !i_ovf && (i_len2 != '0);
            end
            u8ed_pkg::DP_ROW: begin
                o_first_re     = 1'b1;
                o_second_re    = 1'b1;
                o_second_raddr = '0;
                dp_re          = 1'b1;
                dp_raddr       = '0;
            end
            u8ed_pkg::DP_RUN: begin
                dp_we       = 1'b1;
                dp_wdata    = cost;
                dp_re       = !row_last;
                o_second_re = !row_last;
            end
            u8ed_pkg::DP_DONE: begin
                o_done      = 1'b1;
                o_ctl.clear = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    assign o_dist = (r_res > LEN_MAX) ? LEN_MAX : r_res;

    // datapath registers
    always_comb begin
        n_i    = r_i;
        n_j    = r_j;
        n_left = r_left;
        n_diag = r_diag;
        n_res  = r_res;
        case (r_state)
            u8ed_pkg::DP_IDLE: begin
                n_j = ONE;
                n_i = ONE;
            end
            u8ed_pkg::DP_INIT: begin
                n_j = r_j + ONE;
                if (i_ovf) begin
                    n_res = LEN_MAX;
                end else if (i_len1 == '0) begin
                    n_res = i_len2;
                end else begin
                    n_res = i_len1;
                end
            end
            u8ed_pkg::DP_ROW: begin
                n_j    = ONE;
                n_diag = r_i - ONE;
                n_left = r_i;
            end
            u8ed_pkg::DP_RUN: begin
                n_left = cost;
                n_diag = dp_rdata;
                if (row_last) begin
                    n_res = cost;
                    n_i   = r_i + ONE;
                end else begin
                    n_j = r_j + ONE;
                end
            end
            default: begin
                n_i = r_i;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u8ed_pkg::DP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_left <= n_left;
        r_diag <= n_diag;
        r_res  <= n_res;
    end

    `U8ED_ASSERT_ALWAYS(a_no_rw_clash, i_clk, !(dp_we && dp_re && (dp_waddr == dp_raddr)), "row RAM read and write hit one entry")
    `U8ED_ASSERT(a_col_range, i_clk, i_rst_n, (r_state == u8ed_pkg::DP_RUN) |-> ((r_j >= ONE) && (r_j <= i_len2) && (r_i <= i_len1)), "cell index outside the matrix")
    `U8ED_ASSERT(a_done_bound, i_clk, i_rst_n, o_done |-> (r_res <= LEN_MAX) && !$past(o_done), "result out of range or repeated")

endmodule

`default_nettype wire

@@ bench/tb_utf8_edit_distance_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_edit_distance_core
// Self-checking bench for the UTF-8 character edit distance core.
//
// Streams byte words for two strings and finish words into the core, keeps
// its own character-level model of both strings and works out the expected
// distance for each finish. Every result strobe is checked field by field
// against the oldest pending distance. Directed pairs cover character forms,
// cut-short characters, ignored words and the length limit; random pairs
// built from a small character pool cover the rest.
// ----------------------------------------------------------------------------

module tb_utf8_edit_distance_core;

    localparam int         MAXC      = u8ed_pkg::MAX_CHARS_DEF;
    localparam int         N_WORDS   = 1950;      // random part stops past this
    localparam int         POOL_N    = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;      // core ignores this op

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    u8ed_pkg::t_cmd    i_cmd   = '0;
    logic              busy;
    logic              o_valid;
    u8ed_pkg::t_result o_result;

    always #1 i_clk = ~i_clk;

    utf8_edit_distance_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // ------------------------------------------------------------------------
    // Character model of both strings
    // ------------------------------------------------------------------------
    logic [u8ed_pkg::CHAR_W-1:0]      first_str  [MAXC];
    logic [u8ed_pkg::CHAR_W-1:0]      second_str [MAXC];
    int                               first_cnt;
    int                               second_cnt;
    logic [u8ed_pkg::CHAR_DATA_W-1:0] part_bytes;   // character being collected
    int                               part_got;     // 0 = nothing collected
    int                               part_need;
    logic                             part_str;     // 0 first, 1 second
    bit                               dropped_char; // a string ran past MAXC

    u8ed_pkg::t_result distance_queue[$];           // distances still owed by the core

    // run statistics
    int words_sent;
    int pairs_sent;
    int overflow_pairs;
    int longest_first;
    int longest_second;
    int largest_dist;
    int results_seen;
    int errors;

    // char pool for random strings, refilled per pair
    logic [7:0] pool_b [POOL_N][u8ed_pkg::BYTES_MAX];
    int         pool_n [POOL_N];

    int burst_left;

    // bytes per character: 1 for 0xxxxxxx, else 1 + run of ones from bit 6,
    // the run stopping at bit 1 (7 bytes at most)
    function automatic int char_len(input logic [7:0] b);
        int n;
        bit run;
        n   = 1;
        run = b[7];
        for (int k = 6; k >= 1; k--) begin
            run = run & b[k];
            if (run) begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic void close_char();
        logic [2:0] nbytes;
        if (part_got == 0) begin
            return;
        end
        nbytes = part_got[2:0];
        if (part_str == 1'b0) begin
            if (first_cnt < MAXC) begin
                first_str[first_cnt] = {nbytes, part_bytes};
                first_cnt++;
            end else begin
                dropped_char = 1'b1;
            end
        end else begin
            if (second_cnt < MAXC) begin
                second_str[second_cnt] = {nbytes, part_bytes};
                second_cnt++;
            end else begin
                dropped_char = 1'b1;
            end
        end
        part_bytes = '0;
        part_got   = 0;
        part_need  = 0;
    endfunction

    function automatic void absorb_byte(input logic str, input logic [7:0] b);
        // a switch of string closes the pending character as it is
        if (part_got != 0 && part_str != str) begin
            close_char();
        end
        if (part_got == 0) begin
            part_str        = str;
            part_need       = char_len(b);
            part_bytes      = '0;
            part_bytes[7:0] = b;
            part_got        = 1;
        end else begin
            part_bytes[8*part_got +: 8] = b;
            part_got++;
        end
        if (part_got >= part_need) begin
            close_char();
        end
    endfunction

    // unit-cost Levenshtein over whole characters, one row kept
    function automatic int char_distance();
        int row [MAXC+1];
        int diag;
        int above;
        int best;
        for (int j = 0; j <= second_cnt; j++) begin
            row[j] = j;
        end
        for (int i = 1; i <= first_cnt; i++) begin
            diag   = row[0];
            row[0] = i;
            for (int j = 1; j <= second_cnt; j++) begin
                above = row[j];
                if (first_str[i-1] == second_str[j-1]) begin
                    row[j] = diag;
                end else begin
                    best = row[j-1];
                    if (above < best) best = above;
                    if (diag < best)  best = diag;
                    row[j] = best + 1;
                end
                diag = above;
            end
        end
        return row[second_cnt];
    endfunction

    function automatic void finish_pair();
        u8ed_pkg::t_result r;
        int                d;
        close_char();   // a finish mid-character keeps it short
        d = dropped_char ? MAXC : char_distance();
        if (d > MAXC) begin
            d = MAXC;
        end
        r.distance = d[u8ed_pkg::DIST_W-1:0];
        r.overflow = dropped_char;
        distance_queue.insert(distance_queue.size(), r);

        pairs_sent++;
        if (dropped_char) overflow_pairs++;
        if (first_cnt > longest_first)   longest_first  = first_cnt;
        if (second_cnt > longest_second) longest_second = second_cnt;
        if (d > largest_dist)            largest_dist   = d;

        first_cnt    = 0;
        second_cnt   = 0;
        part_bytes   = '0;
        part_got     = 0;
        part_need    = 0;
        part_str     = 1'b0;
        dropped_char = 1'b0;
    endfunction

    function automatic void predict_word(input u8ed_pkg::t_cmd c);
        case (c.op)
            u8ed_pkg::OP_FIRST: begin
                absorb_byte(1'b0, c.data_byte);
            end
            u8ed_pkg::OP_SECOND: begin
                absorb_byte(1'b1, c.data_byte);
            end
            u8ed_pkg::OP_FINISH: begin
                finish_pair();
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender: bursts of random length with random gaps. The gap lowers start
    // at the step after an accept, so start never sees two updates in a step.
    // ------------------------------------------------------------------------
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                // mostly short gaps, now and then one long enough to span
                // a good part of a DP sweep
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60)
                                                  : $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Drive one word and hold it until the core takes it (start && !busy).
    task automatic send_word(input logic [1:0] op, input logic [7:0] b);
        u8ed_pkg::t_cmd c;
        c.op        = op;
        c.data_byte = b;
        pace();
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_word(c);
        if (op != OP_UNUSED) begin
            words_sent++;
        end
    endtask

    task automatic send_run(input logic [1:0] op, input logic [7:0] b, input int n);
        repeat (n) send_word(op, b);
    endtask

    task automatic send_finish();
        send_word(u8ed_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Hold off until every owed distance is back; always lets a clock pass.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (distance_queue.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result checker: the core cannot be stalled, so every strobe is a word.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_result
        u8ed_pkg::t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            results_seen++;
            if (distance_queue.size() == 0) begin
                $error("unexpected result word: distance=%0d overflow=%0b",
                       o_result.distance, o_result.overflow);
                errors++;
            end else begin
                want = distance_queue.pop_front();
                if (o_result.distance !== want.distance) begin
                    $error("distance: expected %0d, actual %0d",
                           want.distance, o_result.distance);
                    errors++;
                end
                if (o_result.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b",
                           want.overflow, o_result.overflow);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Random character generation
    // ------------------------------------------------------------------------
    task automatic make_char(input int slot, input bit noisy);
        logic [7:0] lead;
        int         r;
        r = $urandom_range(0, 99);
        if (noisy && $urandom_range(0, 2) == 0) begin
            lead = 8'($urandom_range(0, 255));
        end else if (r < 40) begin
            lead = 8'($urandom_range(0, 127));
        end else if (r < 60) begin
            lead = 8'(8'hC0 | $urandom_range(0, 31));
        end else if (r < 75) begin
            lead = 8'(8'hE0 | $urandom_range(0, 15));
        end else if (r < 85) begin
            lead = 8'(8'hF0 | $urandom_range(0, 7));
        end else if (r < 93) begin
            lead = 8'(8'hF8 | $urandom_range(0, 7));   // 5 to 7 byte forms
        end else begin
            lead = 8'(8'h80 | $urandom_range(0, 63));  // stray continuation as lead
        end
        pool_n[slot]    = char_len(lead);
        pool_b[slot][0] = lead;
        for (int k = 1; k < u8ed_pkg::BYTES_MAX; k++) begin
            pool_b[slot][k] = noisy ? 8'($urandom_range(0, 255))
                                    : 8'(8'h80 | $urandom_range(0, 63));
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(0, 8);
        if (r < 92) return $urandom_range(9, 24);
        if (r < 98) return $urandom_range(25, MAXC);
        return $urandom_range(MAXC + 1, MAXC + 8);
    endfunction

    // One string pair then a finish. Well-formed pairs switch string only on
    // character boundaries; broken pairs cut characters short, use arbitrary
    // continuation bytes and sprinkle ignored words.
    task automatic run_pair(input int len1, input int len2, input bit broken);
        int   left1;
        int   left2;
        int   slot;
        int   n;
        bit   mixed;
        bit   second_lead;
        logic str;
        for (int s = 0; s < POOL_N; s++) begin
            make_char(s, broken);
        end
        left1       = len1;
        left2       = len2;
        mixed       = 1'($urandom_range(0, 1));
        second_lead = 1'($urandom_range(0, 1));
        while (left1 + left2 > 0) begin
            if (left1 == 0)      str = 1'b1;
            else if (left2 == 0) str = 1'b0;
            else if (mixed)      str = 1'($urandom_range(0, 1));
            else                 str = second_lead;
            slot = $urandom_range(0, POOL_N - 1);
            n    = pool_n[slot];
            if (broken && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, n);
            end
            for (int k = 0; k < n; k++) begin
                send_word(str ? u8ed_pkg::OP_SECOND : u8ed_pkg::OP_FIRST, pool_b[slot][k]);
                if (broken && $urandom_range(0, 15) == 0) begin
                    send_word(OP_UNUSED, 8'($urandom_range(0, 255)));
                end
            end
            if (str) left2--;
            else     left1--;
        end
        send_finish();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty pair, then ASCII extremes: 0x00 and 0x7F against 0x7F.
    task automatic test_basic_strings();
        send_finish();
        send_word(u8ed_pkg::OP_FIRST,  8'h00);
        send_word(u8ed_pkg::OP_FIRST,  8'h7F);
        send_word(u8ed_pkg::OP_SECOND, 8'h7F);
        send_finish();
    endtask

    // Two-byte, 7-byte (0xFF lead, capped run), 6-byte and stray
    // continuation characters.
    task automatic test_char_forms();
        send_word(u8ed_pkg::OP_FIRST, 8'hC3);
        send_word(u8ed_pkg::OP_FIRST, 8'hA9);
        send_word(u8ed_pkg::OP_FIRST, 8'hFF);
        send_run(u8ed_pkg::OP_FIRST, 8'hBF, 6);
        send_word(u8ed_pkg::OP_SECOND, 8'hC3);
        send_word(u8ed_pkg::OP_SECOND, 8'hA9);
        send_word(u8ed_pkg::OP_SECOND, 8'hFC);
        send_run(u8ed_pkg::OP_SECOND, 8'h80, 5);
        send_word(u8ed_pkg::OP_SECOND, 8'h80);
        send_finish();
    endtask

    // A character cut by a string switch, an ignored op between bytes, and
    // one cut by finish.
    task automatic test_cut_chars();
        send_word(u8ed_pkg::OP_FIRST,  8'hE2);
        send_word(u8ed_pkg::OP_FIRST,  8'h82);
        send_word(u8ed_pkg::OP_SECOND, 8'h41);
        send_word(u8ed_pkg::OP_FIRST,  8'hE2);
        send_word(OP_UNUSED,           8'hFF);
        send_word(u8ed_pkg::OP_FIRST,  8'h82);
        send_word(u8ed_pkg::OP_FIRST,  8'hAC);
        send_word(u8ed_pkg::OP_SECOND, 8'hF0);
        send_word(u8ed_pkg::OP_SECOND, 8'h9F);
        send_finish();
    endtask

    // Full-length strings (slowest sweep) and strings past the limit in
    // each direction, draining after each full-length pair and at the end.
    task automatic test_capacity();
        send_run(u8ed_pkg::OP_FIRST,  8'h61, MAXC);
        send_run(u8ed_pkg::OP_SECOND, 8'h62, MAXC);
        send_finish();
        wait_drained();
        send_run(u8ed_pkg::OP_SECOND, 8'h61, MAXC);
        send_run(u8ed_pkg::OP_FIRST,  8'h61, MAXC);
        send_finish();
        wait_drained();
        send_run(u8ed_pkg::OP_FIRST,  8'h61, MAXC + 1);
        send_run(u8ed_pkg::OP_SECOND, 8'h61, 3);
        send_finish();
        send_run(u8ed_pkg::OP_SECOND, 8'h7E, MAXC + 1);
        send_finish();
        // a plain pair right after overflow shows the flag was cleared
        send_word(u8ed_pkg::OP_FIRST,  8'h61);
        send_word(u8ed_pkg::OP_SECOND, 8'h61);
        send_finish();
        wait_drained();
    endtask

    task automatic test_random_pairs();
        while (words_sent < N_WORDS) begin
            run_pair(pick_len(), pick_len(), $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        first_cnt      = 0;
        second_cnt     = 0;
        part_bytes     = '0;
        part_got       = 0;
        part_need      = 0;
        part_str       = 1'b0;
        dropped_char   = 1'b0;
        words_sent     = 0;
        pairs_sent     = 0;
        overflow_pairs = 0;
        longest_first  = 0;
        longest_second = 0;
        largest_dist   = 0;
        results_seen   = 0;
        errors         = 0;
        burst_left     = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_strings();
        test_char_forms();
        test_cut_chars();
        test_capacity();
        test_random_pairs();

        wait_drained();
        repeat (16) @(posedge i_clk);   // catch any stray late strobe

        $display("Covered %0d byte and finish words in %0d string pairs (%0d results), %0d with overflow.",
                 words_sent, pairs_sent, results_seen, overflow_pairs);
        $display("Longest strings %0d x %0d characters, largest distance %0d.",
                 longest_first, longest_second, largest_dist);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #6000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
